FILE: rtl/cgll_pkg.sv
package cgll_pkg;

	localparam int TAG_FIELD_W   = 48;
	localparam int PCNT_W        = 3;
	localparam int LANE_OUT_W    = 5;
	localparam int PARENT_FIELDS = 4;
	localparam int PAR_IDX_W     = 2;
	localparam int BR_SLOTS      = 3;
	localparam int BR_IDX_W      = 2;
	localparam int OUT_CAP       = 40;
	localparam int OUT_CNT_W     = 6;

	typedef enum logic [1:0] {
		EK_MERGE  = 2'd0,
		EK_BRANCH = 2'd1,
		EK_PASS   = 2'd2,
		EK_NONE   = 2'd3
	} edge_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_ROW,
		ST_PLACE,
		ST_SCAN_PAR,
		ST_TAKE_PAR,
		ST_EMIT_MRG,
		ST_EMIT_BR,
		ST_EMIT_PASS,
		ST_FLUSH,
		ST_OVF
	} state_t;

	typedef struct packed {
		logic [LANE_OUT_W-1:0] row_lane;
		logic [LANE_OUT_W-1:0] from_lane;
		logic [LANE_OUT_W-1:0] to_lane;
		edge_kind_t            edge_kind;
		logic                  last_of_row;
		logic                  lane_overflow;
	} res_t;

endpackage

FILE: rtl/cgll_row_if.sv
interface cgll_row_if;
	import cgll_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [TAG_FIELD_W-1:0] commit_tag;
	logic [PCNT_W-1:0]      parent_count;
	logic [TAG_FIELD_W-1:0] parent_a;
	logic [TAG_FIELD_W-1:0] parent_b;
	logic [TAG_FIELD_W-1:0] parent_c;
	logic [TAG_FIELD_W-1:0] parent_d;

	modport source (
		output valid, commit_tag, parent_count, parent_a, parent_b, parent_c, parent_d,
		input  ready
	);

	modport sink (
		input  valid, commit_tag, parent_count, parent_a, parent_b, parent_c, parent_d,
		output ready
	);

endinterface

FILE: rtl/cgll_edge_if.sv
interface cgll_edge_if;
	import cgll_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [LANE_OUT_W-1:0] row_lane;
	logic [LANE_OUT_W-1:0] from_lane;
	logic [LANE_OUT_W-1:0] to_lane;
	edge_kind_t            edge_kind;
	logic                  last_of_row;
	logic                  lane_overflow;

	modport source (
		output valid, row_lane, from_lane, to_lane, edge_kind, last_of_row, lane_overflow,
		input  ready
	);

	modport sink (
		input  valid, row_lane, from_lane, to_lane, edge_kind, last_of_row, lane_overflow,
		output ready
	);

endinterface

FILE: rtl/commit_graph_lane_layout_top.sv
// Commit graph lane layout.
// Channel row (sink): one beat per commit row, its tag, parent count and up to
// four parent tags. Channel edges (source): the edge beats of that row, merges
// in ascending lane order, then branches in parent order, then pass-through
// lines in ascending lane order; last_of_row marks the final beat of a row.
// A row with no edges gives one beat of kind "no edge". A row that needs a lane
// when none is free gives one overflow beat and leaves the lane table as it was.
// Rows are handled one at a time: row.ready is high only while the block idles.
// The wait tags live in a table with one read and one write port that is
// scanned one lane per cycle through one tag comparator, once for the row tag
// and once for each parent after the first, and the edge beats are then walked
// out one lane or branch slot per cycle. The result register holds a finished
// beat while edges.ready is low; the walk halts until the beat is taken,
// nothing is dropped. Reset frees every lane; the tag table needs no clearing.
module commit_graph_lane_layout_top #(
	parameter int MAX_LANES   = 32,
	parameter int MAX_PARENTS = 4,
	parameter int TAG_BITS    = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	cgll_row_if.sink     row,
	cgll_edge_if.source  edges
);
	import cgll_pkg::*;

	localparam int LANE_W = $clog2(MAX_LANES);
	localparam int CNT_W  = $clog2(MAX_LANES + 1);
	localparam int PLIM   = (MAX_PARENTS < PARENT_FIELDS) ? MAX_PARENTS : PARENT_FIELDS;
	localparam int TAG_W  = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;

	function automatic logic [LANE_OUT_W-1:0] lane_out(input logic [LANE_W-1:0] l);
		logic [LANE_W+LANE_OUT_W-1:0] x;
		x = {{LANE_OUT_W{1'b0}}, l};
		return x[LANE_OUT_W-1:0];
	endfunction

	state_t                 state_q, state_d;
	logic [MAX_LANES-1:0]   busy_q, save_q, merged_q, involved_q;
	logic [TAG_W-1:0]       tag_mem [MAX_LANES];
	logic [TAG_W-1:0]       sha_q;
	logic [TAG_W-1:0]       par_q [PARENT_FIELDS];
	logic [PCNT_W-1:0]      np_q, p_q, nbr;
	logic [LANE_W-1:0]      lane_q, free_q, hit_q;
	logic                   found_q, free_v_q, hit_v_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   vld_s1;
	logic [LANE_W-1:0]      idx_s1;
	logic [TAG_W-1:0]       rd_s1;
	logic [LANE_W-1:0]      br_q [BR_SLOTS];
	logic                   pend_v_q;
	logic [LANE_W-1:0]      pend_from_q, pend_to_q;
	edge_kind_t             pend_kind_q;
	logic [OUT_CNT_W-1:0]   out_cnt_q;
	logic                   o_vld_q;
	res_t                   o_q;

	logic                   scanning, scan_start, issue, scan_done;
	logic [TAG_W-1:0]       key;
	logic                   eq, row_match, free_seen, par_hit;
	logic                   place_ok, take_ok;
	logic [LANE_W-1:0]      place_lane, tgt, em_idx;
	logic [BR_IDX_W-1:0]    br_wi;
	logic                   can_push;
	logic                   cand, at_end, em_step, push;
	logic [LANE_W-1:0]      cand_from, cand_to;
	edge_kind_t             cand_kind;
	res_t                   push_res;
	logic                   mem_we;
	logic [LANE_W-1:0]      mem_waddr;
	logic [TAG_W-1:0]       mem_wdata;

	assign scanning   = (state_q == ST_SCAN_ROW) || (state_q == ST_SCAN_PAR);
	assign scan_start = ((state_d == ST_SCAN_ROW) || (state_d == ST_SCAN_PAR)) &&
	                    (state_d != state_q);
	assign issue      = scanning && (cnt_q != CNT_W'(MAX_LANES));
	assign scan_done  = scanning && (cnt_q == CNT_W'(MAX_LANES)) && !vld_s1;
	assign key        = (state_q == ST_SCAN_ROW) ? sha_q : par_q[p_q[PAR_IDX_W-1:0]];
	assign eq         = (rd_s1 == key);
	assign row_match  = vld_s1 && busy_q[idx_s1] && eq;
	assign free_seen  = vld_s1 && !busy_q[idx_s1];
	assign par_hit    = row_match && (idx_s1 != lane_q);
	assign place_ok   = found_q || free_v_q;
	assign place_lane = found_q ? lane_q : free_q;
	assign take_ok    = hit_v_q || free_v_q;
	assign tgt        = hit_v_q ? hit_q : free_q;
	assign br_wi      = BR_IDX_W'(p_q - PCNT_W'(1));
	assign nbr        = (np_q == '0) ? '0 : np_q - PCNT_W'(1);
	assign em_idx     = cnt_q[LANE_W-1:0];
	assign can_push   = !o_vld_q || edges.ready;

	always_comb begin : next_state
		state_d = state_q;
		case (state_q)
		ST_IDLE: begin
			if (row.valid)
				state_d = ST_SCAN_ROW;
		end
		ST_SCAN_ROW: begin
			if (scan_done)
				state_d = ST_PLACE;
		end
		ST_PLACE: begin
			if (!place_ok)
				state_d = ST_OVF;
			else if (np_q > PCNT_W'(1))
				state_d = ST_SCAN_PAR;
			else
				state_d = ST_EMIT_MRG;
		end
		ST_SCAN_PAR: begin
			if (scan_done)
				state_d = ST_TAKE_PAR;
		end
		ST_TAKE_PAR: begin
			if (!take_ok)
				state_d = ST_OVF;
			else if ((p_q + PCNT_W'(1)) == np_q)
				state_d = ST_EMIT_MRG;
			else
				state_d = ST_SCAN_PAR;
		end
		ST_EMIT_MRG: begin
			if (at_end)
				state_d = ST_EMIT_BR;
			else if (push && push_res.last_of_row)
				state_d = ST_IDLE;
		end
		ST_EMIT_BR: begin
			if (at_end)
				state_d = ST_EMIT_PASS;
			else if (push && push_res.last_of_row)
				state_d = ST_IDLE;
		end
		ST_EMIT_PASS: begin
			if (at_end)
				state_d = ST_FLUSH;
			else if (push && push_res.last_of_row)
				state_d = ST_IDLE;
		end
		ST_FLUSH, ST_OVF: begin
			if (can_push)
				state_d = ST_IDLE;
		end
		default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin : outputs
		row.ready = (state_q == ST_IDLE);
		cand      = 1'b0;
		cand_from = em_idx;
		cand_to   = lane_q;
		cand_kind = EK_MERGE;
		at_end    = 1'b0;
		em_step   = 1'b0;
		push      = 1'b0;
		push_res  = '{row_lane: lane_out(lane_q), from_lane: lane_out(pend_from_q),
		              to_lane: lane_out(pend_to_q), edge_kind: pend_kind_q,
		              last_of_row: 1'b0, lane_overflow: 1'b0};
		mem_we    = 1'b0;
		mem_waddr = place_lane;
		mem_wdata = par_q[0];
		case (state_q)
		ST_PLACE: begin
			mem_we = place_ok && (np_q != '0);
		end
		ST_TAKE_PAR: begin
			mem_we    = !hit_v_q && free_v_q;
			mem_waddr = free_q;
			mem_wdata = par_q[p_q[PAR_IDX_W-1:0]];
		end
		ST_EMIT_MRG, ST_EMIT_BR, ST_EMIT_PASS: begin
			if (state_q == ST_EMIT_MRG) begin
				at_end = (cnt_q == CNT_W'(MAX_LANES));
				cand   = !at_end && merged_q[em_idx];
			end else if (state_q == ST_EMIT_BR) begin
				at_end    = (int'(cnt_q) == int'(nbr));
				cand      = !at_end;
				cand_from = lane_q;
				cand_to   = br_q[cnt_q[BR_IDX_W-1:0]];
				cand_kind = EK_BRANCH;
			end else begin
				at_end    = (cnt_q == CNT_W'(MAX_LANES));
				cand      = !at_end && busy_q[em_idx] && !involved_q[em_idx];
				cand_to   = em_idx;
				cand_kind = EK_PASS;
			end
			if (!at_end && !(cand && pend_v_q && !can_push)) begin
				em_step = 1'b1;
				if (cand && pend_v_q) begin
					push                 = 1'b1;
					push_res.last_of_row = (out_cnt_q == OUT_CNT_W'(OUT_CAP - 1));
				end
			end
		end
		ST_FLUSH: begin
			push                 = can_push;
			push_res.last_of_row = 1'b1;
			if (!pend_v_q) begin
				push_res.from_lane = '0;
				push_res.to_lane   = '0;
				push_res.edge_kind = EK_NONE;
			end
		end
		ST_OVF: begin
			push      = can_push;
			push_res  = '{row_lane: '0, from_lane: '0, to_lane: '0, edge_kind: EK_NONE,
			              last_of_row: 1'b1, lane_overflow: 1'b1};
			mem_we    = can_push && found_q && (np_q != '0);
			mem_waddr = lane_q;
			mem_wdata = sha_q;
		end
		default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			tag_mem[mem_waddr] <= mem_wdata;
		rd_s1 <= tag_mem[cnt_q[LANE_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			busy_q     <= '0;
			save_q     <= '0;
			merged_q   <= '0;
			involved_q <= '0;
			np_q       <= '0;
			p_q        <= '0;
			lane_q     <= '0;
			free_q     <= '0;
			hit_q      <= '0;
			found_q    <= 1'b0;
			free_v_q   <= 1'b0;
			hit_v_q    <= 1'b0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			pend_v_q   <= 1'b0;
			out_cnt_q  <= '0;
			o_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (state_d != state_q)
				cnt_q <= '0;
			else if (issue || em_step)
				cnt_q <= cnt_q + CNT_W'(1);

			if (scan_start) begin
				free_v_q <= 1'b0;
				hit_v_q  <= 1'b0;
			end else if (scanning) begin
				if (free_seen && !free_v_q) begin
					free_v_q <= 1'b1;
					free_q   <= idx_s1;
				end
				if ((state_q == ST_SCAN_PAR) && par_hit && !hit_v_q) begin
					hit_v_q <= 1'b1;
					hit_q   <= idx_s1;
				end
			end

			case (state_q)
			ST_IDLE: begin
				if (row.valid) begin
					found_q    <= 1'b0;
					merged_q   <= '0;
					involved_q <= '0;
					save_q     <= busy_q;
					pend_v_q   <= 1'b0;
					out_cnt_q  <= '0;
					if (row.parent_count > PCNT_W'(PLIM))
						np_q <= PCNT_W'(PLIM);
					else
						np_q <= row.parent_count;
				end
			end
			ST_SCAN_ROW: begin
				if (row_match) begin
					if (!found_q) begin
						found_q <= 1'b1;
						lane_q  <= idx_s1;
					end else begin
						merged_q[idx_s1]   <= 1'b1;
						involved_q[idx_s1] <= 1'b1;
						busy_q[idx_s1]     <= 1'b0;
					end
				end
			end
			ST_PLACE: begin
				if (place_ok) begin
					lane_q                 <= place_lane;
					busy_q[place_lane]     <= (np_q != '0);
					involved_q[place_lane] <= 1'b1;
					p_q                    <= PCNT_W'(1);
				end
			end
			ST_TAKE_PAR: begin
				if (take_ok) begin
					busy_q[tgt]     <= 1'b1;
					involved_q[tgt] <= 1'b1;
					p_q             <= p_q + PCNT_W'(1);
				end
			end
			ST_OVF: begin
				if (can_push)
					busy_q <= save_q;
			end
			default: ;
			endcase

			if (em_step && cand)
				pend_v_q <= 1'b1;
			if (push)
				out_cnt_q <= out_cnt_q + OUT_CNT_W'(1);
			if (push)
				o_vld_q <= 1'b1;
			else if (edges.ready)
				o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[LANE_W-1:0];
		if (row.valid && row.ready) begin
			sha_q    <= row.commit_tag[TAG_W-1:0];
			par_q[0] <= row.parent_a[TAG_W-1:0];
			par_q[1] <= row.parent_b[TAG_W-1:0];
			par_q[2] <= row.parent_c[TAG_W-1:0];
			par_q[3] <= row.parent_d[TAG_W-1:0];
		end
		if ((state_q == ST_TAKE_PAR) && take_ok)
			br_q[br_wi] <= tgt;
		if (em_step && cand) begin
			pend_from_q <= cand_from;
			pend_to_q   <= cand_to;
			pend_kind_q <= cand_kind;
		end
		if (push)
			o_q <= push_res;
	end

	assign edges.valid         = o_vld_q;
	assign edges.row_lane      = o_q.row_lane;
	assign edges.from_lane     = o_q.from_lane;
	assign edges.to_lane       = o_q.to_lane;
	assign edges.edge_kind     = o_q.edge_kind;
	assign edges.last_of_row   = o_q.last_of_row;
	assign edges.lane_overflow = o_q.lane_overflow;

	a_idle_table_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(busy_q))
		else $error("lane table changed while idle");

	a_ovf_restores_table: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OVF) && can_push) |=> (busy_q == $past(save_q)))
		else $error("overflow row did not restore the lane table");

	a_cap_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (out_cnt_q == OUT_CNT_W'(OUT_CAP - 1))) |-> push_res.last_of_row)
		else $error("beat at the row cap not marked last");

	a_row_lane_involved: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_PASS) |-> involved_q[lane_q])
		else $error("row lane not excluded from pass-through lines");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scanning |-> !mem_we)
		else $error("tag table written during a scan");

endmodule
